FILE: rtl/pdsd_pkg.sv
// Package for the presence dwell and swipe detector.
// Payload types, register indexes and reset values; no dependencies.
package pdsd_pkg;

   localparam int SAMPLE_W = 7;
   localparam int TIME_W   = 32;
   localparam int DWELL_W  = 16;
   localparam int COUNT_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENCE_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWIPE_THRESHOLD    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS_OFFSET  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DWELL_TIME_MS      = 2'd3;

   localparam logic [SAMPLE_W-1:0] PRESENCE_THRESHOLD_RST = 7'd15;
   localparam logic [SAMPLE_W-1:0] SWIPE_THRESHOLD_RST    = 7'd15;
   localparam logic [SAMPLE_W-1:0] HYSTERESIS_OFFSET_RST  = 7'd5;
   localparam logic [DWELL_W-1:0]  DWELL_TIME_MS_RST      = 16'd2000;

   localparam logic [COUNT_W-1:0]  COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic [SAMPLE_W-1:0] presence_sample;
      logic [SAMPLE_W-1:0] swipe_sample;
      logic [TIME_W-1:0]   time_ms;
   } req_type;

   typedef struct packed {
      logic               user_active;
      logic [COUNT_W-1:0] swipe_count;
      logic               entered_event;
      logic               exited_event;
      logic               swipe_event;
   } rsp_type;

endpackage

FILE: rtl/pdsd_if.sv
// Channel interfaces of the presence dwell and swipe detector.
// Depends on pdsd_pkg for field widths.
interface pdsd_req_if;
   logic                               valid;
   logic                               ready;
   logic [pdsd_pkg::SAMPLE_W-1:0]      presence_sample;
   logic [pdsd_pkg::SAMPLE_W-1:0]      swipe_sample;
   logic [pdsd_pkg::TIME_W-1:0]        time_ms;

   modport source (output valid, presence_sample, swipe_sample, time_ms, input ready);
   modport sink   (input valid, presence_sample, swipe_sample, time_ms, output ready);
endinterface

interface pdsd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               user_active;
   logic [pdsd_pkg::COUNT_W-1:0]       swipe_count;
   logic                               entered_event;
   logic                               exited_event;
   logic                               swipe_event;

   modport source (output valid, user_active, swipe_count, entered_event, exited_event,
                   swipe_event, input ready);
   modport sink   (input valid, user_active, swipe_count, entered_event, exited_event,
                   swipe_event, output ready);
endinterface

interface pdsd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [pdsd_pkg::CSR_IDX_W-1:0]     index;
   logic [pdsd_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/presence_dwell_and_swipe_detector.sv
// Presence dwell and swipe detector, top level.
// Depends on pdsd_pkg and the channel interfaces in pdsd_if.sv.
//
// req_ch carries one beat per sensor sample: presence, swipe and a ms timestamp.
// rsp_ch returns exactly one beat per request beat, in order: the session flag,
// the swipe count and the entered / exited / swipe events caused by that sample.
// csr_ch writes the four registers (presence threshold, swipe threshold,
// hysteresis offset, dwell time) by index; it is always ready, and writes are
// expected only while no sample is in flight.
//
// A request beat lands in an input register; the detector state then updates from it
// and the result is loaded into the output register, which drives rsp_ch. One beat
// per cycle is taken in steady state while rsp_ch does not stall: the state update
// is a single pass of compare logic plus a 32-bit elapsed-time subtract and compare.
// When rsp_ch stalls, the output and input registers hold; req_ch.ready drops
// only when both are full, so one more beat is taken behind a stalled result.
// Reset (synchronous) clears the session, dwell timer, swipe state and counter,
// restores the register defaults and empties both pipeline registers.
module presence_dwell_and_swipe_detector (
   input  logic clock,
   input  logic reset,
   pdsd_req_if.sink   req_ch,
   pdsd_rsp_if.source rsp_ch,
   pdsd_csr_if.sink   csr_ch
);

   logic [pdsd_pkg::SAMPLE_W-1:0] presence_threshold_ff;
   logic [pdsd_pkg::SAMPLE_W-1:0] swipe_threshold_ff;
   logic [pdsd_pkg::SAMPLE_W-1:0] hysteresis_offset_ff;
   logic [pdsd_pkg::DWELL_W-1:0]  dwell_time_ms_ff;

   logic                          active_ff, active_in;
   logic                          dwell_running_ff, dwell_running_in;
   logic [pdsd_pkg::TIME_W-1:0]   dwell_start_ff, dwell_start_in;
   logic                          swipe_high_ff, swipe_high_in;
   logic [pdsd_pkg::COUNT_W-1:0]  counter_ff, counter_in;

   logic                          stage_valid_ff;
   pdsd_pkg::req_type             stage_ff;
   logic                          rsp_valid_ff;
   pdsd_pkg::rsp_type             rsp_ff, rsp_in;

   logic                          advance;
   logic                          take;

   assign advance = stage_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign take    = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !stage_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.user_active   = rsp_ff.user_active;
   assign rsp_ch.swipe_count   = rsp_ff.swipe_count;
   assign rsp_ch.entered_event = rsp_ff.entered_event;
   assign rsp_ch.exited_event  = rsp_ff.exited_event;
   assign rsp_ch.swipe_event   = rsp_ff.swipe_event;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         presence_threshold_ff <= pdsd_pkg::PRESENCE_THRESHOLD_RST;
         swipe_threshold_ff    <= pdsd_pkg::SWIPE_THRESHOLD_RST;
         hysteresis_offset_ff  <= pdsd_pkg::HYSTERESIS_OFFSET_RST;
         dwell_time_ms_ff      <= pdsd_pkg::DWELL_TIME_MS_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            pdsd_pkg::CSR_PRESENCE_THRESHOLD:
               presence_threshold_ff <= csr_ch.data[pdsd_pkg::SAMPLE_W-1:0];
            pdsd_pkg::CSR_SWIPE_THRESHOLD:
               swipe_threshold_ff <= csr_ch.data[pdsd_pkg::SAMPLE_W-1:0];
            pdsd_pkg::CSR_HYSTERESIS_OFFSET:
               hysteresis_offset_ff <= csr_ch.data[pdsd_pkg::SAMPLE_W-1:0];
            pdsd_pkg::CSR_DWELL_TIME_MS:
               dwell_time_ms_ff <= csr_ch.data[pdsd_pkg::DWELL_W-1:0];
            default: ;
         endcase
      end
   end

   // detector update for the sample in the input register
   always_comb begin
      logic signed [pdsd_pkg::SAMPLE_W:0] pres_low;
      logic signed [pdsd_pkg::SAMPLE_W:0] swp_low;
      logic signed [pdsd_pkg::SAMPLE_W:0] pres_s;
      logic signed [pdsd_pkg::SAMPLE_W:0] swp_s;
      logic [pdsd_pkg::TIME_W-1:0]        elapsed;
      logic                               expired;
      logic                               pres_high;
      logic                               entered;
      logic                               exited;
      logic                               swiped;

      // falling levels may go negative; one extra bit keeps them signed
      pres_low = $signed({1'b0, presence_threshold_ff}) - $signed({1'b0, hysteresis_offset_ff});
      swp_low  = $signed({1'b0, swipe_threshold_ff}) - $signed({1'b0, hysteresis_offset_ff});
      pres_s   = $signed({1'b0, stage_ff.presence_sample});
      swp_s    = $signed({1'b0, stage_ff.swipe_sample});
      elapsed  = stage_ff.time_ms - dwell_start_ff;
      expired  = elapsed >= {{(pdsd_pkg::TIME_W-pdsd_pkg::DWELL_W){1'b0}}, dwell_time_ms_ff};
      pres_high = stage_ff.presence_sample > presence_threshold_ff;

      active_in        = active_ff;
      dwell_running_in = dwell_running_ff;
      dwell_start_in   = dwell_start_ff;
      swipe_high_in    = swipe_high_ff;
      counter_in       = counter_ff;
      entered          = 1'b0;
      exited           = 1'b0;
      swiped           = 1'b0;

      if (pres_high && !active_ff) begin
         if (!dwell_running_ff) begin
            dwell_running_in = 1'b1;
            dwell_start_in   = stage_ff.time_ms;
         end else if (expired) begin
            active_in        = 1'b1;
            dwell_running_in = 1'b0;
            counter_in       = '0;
            entered          = 1'b1;
         end
      end

      // a high sample never reaches this arm, so it sees the old session state
      if (pres_s < pres_low) begin
         if (active_ff) begin
            active_in = 1'b0;
            exited    = 1'b1;
         end else if (dwell_running_ff && expired) begin
            dwell_running_in = 1'b0;
         end
      end

      // arm and complete cannot both happen on one sample
      if (active_in) begin
         if (!swipe_high_ff && stage_ff.swipe_sample > swipe_threshold_ff) begin
            swipe_high_in = 1'b1;
         end
         if (swipe_high_ff && swp_s < swp_low) begin
            swipe_high_in = 1'b0;
            swiped        = 1'b1;
            if (counter_in != pdsd_pkg::COUNT_MAX) begin
               counter_in = counter_in + 1'b1;
            end
         end
      end

      rsp_in.user_active   = active_in;
      rsp_in.swipe_count   = counter_in;
      rsp_in.entered_event = entered;
      rsp_in.exited_event  = exited;
      rsp_in.swipe_event   = swiped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff        <= 1'b0;
         dwell_running_ff <= 1'b0;
         dwell_start_ff   <= '0;
         swipe_high_ff    <= 1'b0;
         counter_ff       <= '0;
         stage_valid_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (advance) begin
            active_ff        <= active_in;
            dwell_running_ff <= dwell_running_in;
            dwell_start_ff   <= dwell_start_in;
            swipe_high_ff    <= swipe_high_in;
            counter_ff       <= counter_in;
         end
         if (req_ch.ready) begin
            stage_valid_ff <= take;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         stage_ff.presence_sample <= req_ch.presence_sample;
         stage_ff.swipe_sample    <= req_ch.swipe_sample;
         stage_ff.time_ms         <= req_ch.time_ms;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
